@@ hdl/cmag_pkg.sv @@
// Package for the complex magnitude block: widths, the data carried between
// square-root cells, and the output saturation function. No dependencies.
package cmag_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FIELD_BITS  = 16;
  localparam int MAG_BITS    = 16;

  // The field is viewed at this width so that any SAMPLE_BITS can take its low bits.
  localparam int EXT_BITS  = (SAMPLE_BITS > FIELD_BITS) ? SAMPLE_BITS : FIELD_BITS;
  localparam int ABS_BITS  = SAMPLE_BITS;
  localparam int SQ_BITS   = 2 * SAMPLE_BITS;
  localparam int RAD_BITS  = 2 * SAMPLE_BITS;
  localparam int ROOT_BITS = SAMPLE_BITS;
  localparam int REM_BITS  = SAMPLE_BITS + 2;
  localparam int CELLS     = SAMPLE_BITS;
  localparam int WIDE_BITS = (ROOT_BITS > MAG_BITS) ? ROOT_BITS : MAG_BITS;

  typedef struct packed {
    logic [RAD_BITS-1:0]  rad;
    logic [REM_BITS-1:0]  rem;
    logic [ROOT_BITS-1:0] root;
    logic                 row_end;
  } cell_data_t;

  function automatic logic [MAG_BITS-1:0] sat_mag(input logic [ROOT_BITS-1:0] root);
    logic [WIDE_BITS-1:0] w;
    logic [WIDE_BITS-1:0] lim;
    w   = WIDE_BITS'(root);
    lim = WIDE_BITS'({MAG_BITS{1'b1}});
    if (w > lim) begin
      sat_mag = {MAG_BITS{1'b1}};
    end else begin
      sat_mag = MAG_BITS'(w);
    end
  endfunction

endpackage

@@ hdl/cmag_if.sv @@
// Valid/ready channel interfaces for complex samples and magnitude results.
// Depends on cmag_pkg for the field widths.
interface cmag_in_if import cmag_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] real_part;
  logic [FIELD_BITS-1:0] imag_part;
  logic                  row_end_in;

  modport source (output valid, output real_part, output imag_part, output row_end_in,
                  input ready);
  modport sink   (input valid, input real_part, input imag_part, input row_end_in,
                  output ready);
endinterface

interface cmag_out_if import cmag_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MAG_BITS-1:0] magnitude;
  logic                row_end_out;

  modport source (output valid, output magnitude, output row_end_out, input ready);
  modport sink   (input valid, input magnitude, input row_end_out, output ready);
endinterface

@@ hdl/cmag_sumsq.sv @@
// Front end: absolute values, squares and their sum, in two registered stages.
// Depends on cmag_pkg; feeds the first square-root cell.
module cmag_sumsq import cmag_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  up_valid,
  input  logic [FIELD_BITS-1:0] real_part,
  input  logic [FIELD_BITS-1:0] imag_part,
  input  logic                  row_end_in,
  output logic                  up_ready,
  output logic                  dn_valid,
  output cell_data_t            dn_data,
  input  logic                  dn_ready
);

  logic               sq_valid;
  logic               sq_ready;
  logic [SQ_BITS-1:0] sq_re;
  logic [SQ_BITS-1:0] sq_im;
  logic               sq_row_end;
  logic [ABS_BITS-1:0] abs_re;
  logic [ABS_BITS-1:0] abs_im;
  logic [EXT_BITS-1:0] ext_re;
  logic [EXT_BITS-1:0] ext_im;
  logic [SAMPLE_BITS-1:0] s_re;
  logic [SAMPLE_BITS-1:0] s_im;

  always_comb begin
    ext_re = EXT_BITS'(real_part);
    ext_im = EXT_BITS'(imag_part);
    s_re   = ext_re[SAMPLE_BITS-1:0];
    s_im   = ext_im[SAMPLE_BITS-1:0];
    abs_re = s_re[SAMPLE_BITS-1] ? ABS_BITS'(-s_re) : ABS_BITS'(s_re);
    abs_im = s_im[SAMPLE_BITS-1] ? ABS_BITS'(-s_im) : ABS_BITS'(s_im);
  end

  assign sq_ready = !dn_valid || dn_ready;
  assign up_ready = !sq_valid || sq_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else if (up_ready) begin
      sq_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      sq_re      <= SQ_BITS'(abs_re * abs_re);
      sq_im      <= SQ_BITS'(abs_im * abs_im);
      sq_row_end <= row_end_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (sq_ready) begin
      dn_valid <= sq_valid;
    end
  end

  // The largest sum is 2 * 2^(2*SAMPLE_BITS-2), which still fits the radicand.
  always_ff @(posedge clk) begin
    if (sq_valid && sq_ready) begin
      dn_data.rad     <= RAD_BITS'(sq_re + sq_im);
      dn_data.rem     <= '0;
      dn_data.root    <= '0;
      dn_data.row_end <= sq_row_end;
    end
  end

endmodule

@@ hdl/cmag_cell.sv @@
// One cell of the square-root chain: takes two radicand bits, decides one
// root bit, and hands radicand, remainder and root to the next cell. Uses cmag_pkg.
module cmag_cell import cmag_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       up_valid,
  input  cell_data_t up_data,
  output logic       up_ready,
  output logic       dn_valid,
  output cell_data_t dn_data,
  input  logic       dn_ready
);

  logic [REM_BITS-1:0] acc;
  logic [REM_BITS-1:0] trial;
  cell_data_t          nxt;

  always_comb begin
    acc   = {up_data.rem[REM_BITS-3:0], up_data.rad[RAD_BITS-1 -: 2]};
    trial = REM_BITS'({up_data.root, 2'b01});
    nxt.rad     = {up_data.rad[RAD_BITS-3:0], 2'b00};
    nxt.row_end = up_data.row_end;
    if (acc >= trial) begin
      nxt.rem  = acc - trial;
      nxt.root = {up_data.root[ROOT_BITS-2:0], 1'b1};
    end else begin
      nxt.rem  = acc;
      nxt.root = {up_data.root[ROOT_BITS-2:0], 1'b0};
    end
  end

  // A cell whose register is empty or being drained can take a new transaction.
  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_data <= nxt;
    end
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    dn_valid |-> dn_data.rem <= REM_BITS'({dn_data.root, 1'b0}))
    else $error("square-root remainder exceeds twice the partial root");

  a_load: assert property (@(posedge clk) disable iff (rst)
    up_valid && up_ready |=> dn_valid)
    else $error("accepted transaction did not reach the cell register");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    dn_valid && !dn_ready |=> dn_valid && $stable(dn_data))
    else $error("stalled cell lost or changed its contents");

endmodule

@@ hdl/complex_magnitude.sv @@
// Complex magnitude: floor(sqrt(re*re + im*im)) of Q1.15 samples.
// From accept to result valid, a sample is registered in the front end and then in each cell.
// Throughput: one transaction per cycle while results.ready holds; each root bit is one cell of the chain.
// A stall holds only the stages that are full; bubbles are squeezed out.
// Reset clears every stage valid bit; data registers are not reset.
// Depends on cmag_pkg, cmag_if, cmag_sumsq and cmag_cell.
module complex_magnitude import cmag_pkg::*; (
  input logic        clk,
  input logic        rst,
  cmag_in_if.sink    samples,
  cmag_out_if.source results
);

  logic       stg_valid [CELLS+1];
  logic       stg_ready [CELLS+1];
  cell_data_t stg_data  [CELLS+1];

  cmag_sumsq u_sumsq (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (samples.valid),
    .real_part  (samples.real_part),
    .imag_part  (samples.imag_part),
    .row_end_in (samples.row_end_in),
    .up_ready   (samples.ready),
    .dn_valid   (stg_valid[0]),
    .dn_data    (stg_data[0]),
    .dn_ready   (stg_ready[0])
  );

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    cmag_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (stg_valid[i]),
      .up_data  (stg_data[i]),
      .up_ready (stg_ready[i]),
      .dn_valid (stg_valid[i+1]),
      .dn_data  (stg_data[i+1]),
      .dn_ready (stg_ready[i+1])
    );
  end

  // The last cell register is the output register.
  assign stg_ready[CELLS]    = results.ready;
  assign results.valid       = stg_valid[CELLS];
  assign results.magnitude   = sat_mag(stg_data[CELLS].root);
  assign results.row_end_out = stg_data[CELLS].row_end;

endmodule

@@ tb/cmag_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the complex magnitude block: watches both channels, predicts
// each magnitude from the accepted sample and compares it. Depends on cmag_pkg, cmag_if.
module cmag_checker import cmag_pkg::*; (
  input  logic clk,
  input  logic rst,
  cmag_in_if   samples,
  cmag_out_if  results,
  output int   fail_count,
  output int   pending_count
);

  // Roots above this value saturate.
  localparam longint unsigned MAG_CEILING = 64'hFFFF;

  typedef struct packed {
    logic [MAG_BITS-1:0] magnitude;
    logic                row_end;
  } mag_result_t;

  mag_result_t expected_mags[$];

  // The component is the low SAMPLE_BITS of the field, taken as two's complement.
  function automatic longint unsigned component_abs(input logic [FIELD_BITS-1:0] field);
    logic [EXT_BITS-1:0]    ext;
    logic [SAMPLE_BITS-1:0] v;
    ext = EXT_BITS'(field);
    v = ext[SAMPLE_BITS-1:0];
    if (v[SAMPLE_BITS-1]) begin
      v = -v;
    end
    return longint'(v);
  endfunction

  // Floor of the square root, found one root bit at a time from the top.
  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) begin
        root = trial;
      end
    end
    return root;
  endfunction

  function automatic mag_result_t predict_magnitude(input logic [FIELD_BITS-1:0] re,
                                                    input logic [FIELD_BITS-1:0] im,
                                                    input logic row_end);
    longint unsigned re_abs;
    longint unsigned im_abs;
    longint unsigned root;
    mag_result_t r;
    re_abs = component_abs(re);
    im_abs = component_abs(im);
    root = floor_root(re_abs * re_abs + im_abs * im_abs);
    if (root > MAG_CEILING) begin
      root = MAG_CEILING;
    end
    r.magnitude = MAG_BITS'(root);
    r.row_end   = row_end;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fail_count++;
  endtask

  // All drivers update on the clock edge, so the values read here are the ones
  // that were present at the edge.
  always @(posedge clk) begin : watch
    mag_result_t want;
    if (!rst) begin
      if (results.valid && results.ready) begin
        if (expected_mags.size() == 0) begin
          report_mismatch($sformatf("result transaction with no sample pending, magnitude %0d",
                                    results.magnitude));
        end else begin
          want = expected_mags.pop_front();
          if (results.magnitude !== want.magnitude) begin
            report_mismatch($sformatf("magnitude expected %0d, got %0d",
                                      want.magnitude, results.magnitude));
          end
          if (results.row_end_out !== want.row_end) begin
            report_mismatch($sformatf("row_end_out expected %0b, got %0b",
                                      want.row_end, results.row_end_out));
          end
        end
      end
      if (samples.valid && samples.ready) begin
        expected_mags.push_back(predict_magnitude(samples.real_part, samples.imag_part,
                                                  samples.row_end_in));
      end
    end
    pending_count <= expected_mags.size();
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Top of the complex magnitude testbench: clock, reset, sample stimulus and
// result back-pressure. Depends on cmag_pkg, cmag_if, complex_magnitude, cmag_checker.
module tb_top import cmag_pkg::*; ();

  localparam int RANDOM_ITEMS   = 1230;
  localparam int STEADY_ITEMS   = 250;
  localparam int HOLD_AFTER     = 200;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DIRECTED_ITEMS = 20;

  localparam logic [FIELD_BITS-1:0] DIRECTED_RE [DIRECTED_ITEMS] = '{
    16'h0000, 16'h7FFF, 16'h0000, 16'h8000, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000,
    16'h7FFF, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0003, 16'hFFFD, 16'h5555, 16'hAAAA,
    16'h8001, 16'h00FF, 16'h4000, 16'hC000};
  localparam logic [FIELD_BITS-1:0] DIRECTED_IM [DIRECTED_ITEMS] = '{
    16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
    16'h8000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0004, 16'hFFFC, 16'hAAAA, 16'h5555,
    16'h8001, 16'h0100, 16'h4000, 16'h4000};

  logic clk = 1'b0;
  logic rst;
  bit   idling_on;
  int   fails;
  int   pending;
  int   quiet_cycles;

  cmag_in_if  samples_if ();
  cmag_out_if results_if ();

  complex_magnitude i_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .results (results_if)
  );

  cmag_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .samples       (samples_if),
    .results       (results_if),
    .fail_count    (fails),
    .pending_count (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Mostly full-range values, with a share of tiny values and of the extremes.
  function automatic logic [FIELD_BITS-1:0] random_component();
    logic [FIELD_BITS-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        v = FIELD_BITS'($urandom_range(0, 15));
        if ($urandom_range(0, 1)) begin
          v = -v;
        end
      end
      1: begin
        case ($urandom_range(0, 3))
          0: v = {1'b1, {(FIELD_BITS-1){1'b0}}};
          1: v = {1'b0, {(FIELD_BITS-1){1'b1}}};
          2: v = {FIELD_BITS{1'b1}};
          default: v = {1'b1, {(FIELD_BITS-2){1'b0}}, 1'b1};
        endcase
      end
      default: v = FIELD_BITS'($urandom());
    endcase
    return v;
  endfunction

  // Offers one sample and returns at the edge where it is accepted.
  task automatic send_sample(input logic [FIELD_BITS-1:0] re, input logic [FIELD_BITS-1:0] im,
                             input logic row_end);
    int gap;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      samples_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples_if.valid      <= 1'b1;
    samples_if.real_part  <= re;
    samples_if.imag_part  <= im;
    samples_if.row_end_in <= row_end;
    do @(posedge clk); while (!samples_if.ready);
  endtask

  initial begin : stimulus
    int row_left;
    rst                   <= 1'b1;
    samples_if.valid      <= 1'b0;
    samples_if.real_part  <= '0;
    samples_if.imag_part  <= '0;
    samples_if.row_end_in <= 1'b0;
    idling_on = 1'b1;
    row_left  = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ITEMS; i++) begin
      send_sample(DIRECTED_RE[i], DIRECTED_IM[i], i[0]);
    end

    // Random samples framed into rows of random length.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - STEADY_ITEMS) begin
        idling_on = 1'b0;
      end
      if (row_left == 0) begin
        row_left = $urandom_range(1, 12);
      end
      send_sample(random_component(), random_component(), row_left == 1);
      row_left--;
    end
    samples_if.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Result side: short random stalls, plus one long hold-off that lets the
  // pipeline fill up and push back on the sample channel.
  initial begin : result_sink
    int taken;
    int stall_left;
    bit held;
    taken      = 0;
    stall_left = 0;
    held       = 1'b0;
    results_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && taken >= HOLD_AFTER) begin
        held       = 1'b1;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && idling_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4);
      end
      results_if.ready <= (stall_left == 0);
      if (stall_left != 0) begin
        stall_left--;
      end
      @(posedge clk);
      if (results_if.valid && results_if.ready) begin
        taken++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (samples_if.valid && samples_if.ready) ||
        (results_if.valid && results_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
